/* rtl/core/ghi_pkg.sv */
// Shared widths, types and the CORDIC angle table for the gyro heading integrator.
`timescale 1ns / 1ps
package ghi_pkg;

    localparam int RATE_W  = 20;
    localparam int DT_W    = 20;
    localparam int PROD_W  = RATE_W + DT_W;
    localparam int ACC_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int Q_W     = 16;
    localparam int CW      = 34;   // CORDIC datapath: Q2.30 plus guard bits
    localparam int STAGES_DEF = 16;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Payload handed from cell to cell
    typedef struct packed {
        logic signed [CW-1:0]     x;
        logic signed [CW-1:0]     y;
        logic signed [CW-1:0]     z;
        logic [HEAD_W-1:0]        heading;
        logic signed [RATE_W-1:0] rate;
    } t_cell;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [ACC_W-1:0] atan_turn(input int idx);
        logic [ACC_W-1:0] v;
        begin
            case (idx)
                0:  v = 32'd536870912;
                1:  v = 32'd316933406;
                2:  v = 32'd167458907;
                3:  v = 32'd85004756;
                4:  v = 32'd42667331;
                5:  v = 32'd21354465;
                6:  v = 32'd10679838;
                7:  v = 32'd5340245;
                8:  v = 32'd2670163;
                9:  v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41722;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                23: v = 32'd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* rtl/core/ghi_ifs.sv */
// Valid/ready channel interfaces for gyro requests and pose results.
`timescale 1ns / 1ps
interface ghi_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [ghi_pkg::RATE_W-1:0] gyro_rate;
    logic [ghi_pkg::DT_W-1:0]       elapsed;
    logic                           gyro_valid;

    modport source (output valid, gyro_rate, elapsed, gyro_valid, input ready);
    modport sink   (input valid, gyro_rate, elapsed, gyro_valid, output ready);
endinterface

interface ghi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ghi_pkg::HEAD_W-1:0] heading;
    logic signed [ghi_pkg::Q_W-1:0]    quat_z;
    logic signed [ghi_pkg::Q_W-1:0]    quat_w;
    logic signed [ghi_pkg::RATE_W-1:0] rate_out;

    modport source (output valid, heading, quat_z, quat_w, rate_out, input ready);
    modport sink   (input valid, heading, quat_z, quat_w, rate_out, output ready);
endinterface

/* rtl/core/ghi_accum.sv */
// Rate times elapsed product stage and heading accumulator stage.
`timescale 1ns / 1ps
module ghi_accum
    import ghi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ghi_in_if.sink    i_gyro,
    output logic      o_valid,
    output t_cell     o_data,
    input  logic      i_ready
);

    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RATE_W-1:0] r_a_rate;
    logic                     r_b_valid;
    t_cell                    r_b_data;
    logic [ACC_W-1:0]         r_accum;

    logic                     a_ready;
    logic                     b_ready;
    logic                     n_a_valid;
    logic signed [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0]        rounded;
    logic [ACC_W-1:0]         n_accum;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign i_gyro.ready = a_ready;

    // zero time step or missing sample is swallowed here
    assign n_a_valid = i_gyro.valid && i_gyro.gyro_valid && (i_gyro.elapsed != '0);
    assign n_prod    = i_gyro.gyro_rate * $signed({1'b0, i_gyro.elapsed});

    // round 2^-36 turn to 2^-32 turn; the low 32 bits of the shift are all that matter
    assign rounded = r_prod + PROD_W'(8);
    assign n_accum = r_accum + rounded[ACC_W+3:4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= n_a_valid;
        end
        if (a_ready) begin
            r_prod   <= n_prod;
            r_a_rate <= i_gyro.gyro_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_accum   <= '0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
            if (r_a_valid) begin
                r_accum <= n_accum;
            end
        end
        if (b_ready && r_a_valid) begin
            r_b_data.x       <= CORDIC_GAIN;
            r_b_data.y       <= '0;
            // accumulator read signed is the half angle in 2^-33 turn
            r_b_data.z       <= CW'($signed(n_accum));
            r_b_data.heading <= n_accum[ACC_W-1:ACC_W-HEAD_W];
            r_b_data.rate    <= r_a_rate;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

`ifndef SYNTHESIS
    a_accum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(b_ready && r_a_valid) |=> $stable(r_accum))
        else $error("heading accumulator changed without an item");
    a_drop_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_gyro.valid && a_ready && (!i_gyro.gyro_valid || i_gyro.elapsed == '0))
        |=> !r_a_valid)
        else $error("dropped request entered the product stage");
`endif

endmodule

/* rtl/core/ghi_cordic_cell.sv */
// One CORDIC rotation cell with its own pipeline register and handshake.
`timescale 1ns / 1ps
module ghi_cordic_cell
    import ghi_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cell i_data,
    output logic  o_ready,
    output logic  o_valid,
    output t_cell o_data,
    input  logic  i_ready
);

    // doubled table entry: half angle is in 2^-33 turn
    localparam logic signed [CW-1:0] ANGLE = {1'b0, atan_turn(STAGE), 1'b0};

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = i_data.x >>> STAGE;
    assign ys = i_data.y >>> STAGE;

    always_comb begin
        n_data = i_data;
        if (!i_data.z[CW-1]) begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ANGLE;
        end else begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ANGLE;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    a_cell_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_data)))
        else $error("stalled CORDIC cell lost its contents");
`endif

endmodule

/* rtl/core/ghi_out_stage.sv */
// Q1.15 rounding, saturation and the result register.
`timescale 1ns / 1ps
module ghi_out_stage
    import ghi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_cell     i_data,
    output logic      o_ready,
    ghi_out_if.source o_pose
);

    localparam logic signed [CW:0]   HALF_LSB = (CW+1)'(1 << 14);
    localparam logic signed [CW-15:0] Q_MAX   = (CW-14)'(32767);
    localparam logic signed [CW-15:0] Q_MIN   = -(CW-14)'(32768);

    logic                     r_valid;
    logic signed [HEAD_W-1:0] r_heading;
    logic signed [Q_W-1:0]    r_quat_z;
    logic signed [Q_W-1:0]    r_quat_w;
    logic signed [RATE_W-1:0] r_rate;

    logic signed [CW:0]    y_sum;
    logic signed [CW:0]    x_sum;
    logic signed [CW-15:0] y_q;
    logic signed [CW-15:0] x_q;
    logic signed [Q_W-1:0] n_quat_z;
    logic signed [Q_W-1:0] n_quat_w;

    assign y_sum = $signed({i_data.y[CW-1], i_data.y}) + HALF_LSB;
    assign x_sum = $signed({i_data.x[CW-1], i_data.x}) + HALF_LSB;
    assign y_q   = y_sum[CW:15];
    assign x_q   = x_sum[CW:15];

    always_comb begin
        if (y_q > Q_MAX) begin
            n_quat_z = Q_W'(Q_MAX);
        end else if (y_q < Q_MIN) begin
            n_quat_z = Q_W'(Q_MIN);
        end else begin
            n_quat_z = y_q[Q_W-1:0];
        end
        // cosine of half heading is clamped at zero from below
        if (x_q > Q_MAX) begin
            n_quat_w = Q_W'(Q_MAX);
        end else if (x_q[CW-15]) begin
            n_quat_w = '0;
        end else begin
            n_quat_w = x_q[Q_W-1:0];
        end
    end

    assign o_ready = !r_valid || o_pose.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_heading <= i_data.heading;
            r_quat_z  <= n_quat_z;
            r_quat_w  <= n_quat_w;
            r_rate    <= i_data.rate;
        end
    end

    assign o_pose.valid    = r_valid;
    assign o_pose.heading  = r_heading;
    assign o_pose.quat_z   = r_quat_z;
    assign o_pose.quat_w   = r_quat_w;
    assign o_pose.rate_out = r_rate;

`ifndef SYNTHESIS
    a_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !r_quat_w[Q_W-1])
        else $error("quaternion w went negative");
`endif

endmodule

/* rtl/core/gyro_heading_integrator_unit.sv */
// Top level: gyro yaw integrator with wrapped heading and CORDIC yaw quaternion.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   i_gyro   | in  | valid / ready | gyro_rate, elapsed, gyro_valid
//   o_pose   | out | valid / ready | heading, quat_z, quat_w, rate_out
//
// One request per cycle sustained while o_pose is ready; each request passes through the
// product register, accumulator register, one cell per CORDIC stage and the output register.
// Each stage holds its own valid bit and frees itself when its successor takes the item,
// so bubbles collapse and requests are taken while a result waits on o_pose.
// Requests with zero elapsed time or gyro_valid low are taken and dropped without a result.
// Synchronous active-low reset clears the valid bits and the heading accumulator to zero.
`timescale 1ns / 1ps
module gyro_heading_integrator_unit
    import ghi_pkg::*;
#(
    parameter int CORDIC_STAGES = STAGES_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ghi_in_if.sink    i_gyro,
    ghi_out_if.source o_pose
);

    logic  s_valid [CORDIC_STAGES+1];
    logic  s_ready [CORDIC_STAGES+1];
    t_cell s_data  [CORDIC_STAGES+1];

    ghi_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gyro  (i_gyro),
        .o_valid (s_valid[0]),
        .o_data  (s_data[0]),
        .i_ready (s_ready[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ghi_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .i_data  (s_data[g]),
            .o_ready (s_ready[g]),
            .o_valid (s_valid[g+1]),
            .o_data  (s_data[g+1]),
            .i_ready (s_ready[g+1])
        );
    end

    ghi_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[CORDIC_STAGES]),
        .i_data  (s_data[CORDIC_STAGES]),
        .o_ready (s_ready[CORDIC_STAGES]),
        .o_pose  (o_pose)
    );

endmodule
